>>> hw/rtl/cwec_pkg.sv
// Shared types, constants and helpers for the component wall edge counter.
// Depends on nothing; the front end, back end, top level and checker use it by scoped names.
package cwec_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int SLOT_W     = CELL_W + 1;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int CFG_W      = 7;
    localparam int CNT_W      = 15;
    localparam int EPOCH_W    = 8;
    localparam int ANS_W      = EPOCH_W + CNT_W;
    localparam int IDX_W      = 2;

    localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [IDX_W-1:0] REG_GRID_ROWS = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_GRID_COLS = IDX_W'(1);

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic             op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             is_wall;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] edge_count;
        logic             on_wall;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } grid_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_WALL,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             is_wall;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_Q_CHECK,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_NB_RD,
        ST_NB_EV,
        ST_FILL_RD,
        ST_FILL_WR
    } back_state_t;

    function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        cell_of = CELL_W'(r) * CELL_W'(MAX_COLS) + CELL_W'(c);
    endfunction

    function automatic logic [ROW_W-1:0] row_of(input logic [CELL_W-1:0] cell_idx);
        row_of = ROW_W'(cell_idx / MAX_COLS);
    endfunction

    function automatic logic [COL_W-1:0] col_of(input logic [CELL_W-1:0] cell_idx);
        col_of = COL_W'(cell_idx % MAX_COLS);
    endfunction

endpackage

>>> hw/rtl/cwec_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module cwec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/cwec_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on cwec_pkg.
module cwec_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cwec_pkg::in_item_t    in_data,
    input  cwec_pkg::grid_t       grid,
    input  logic                  hold,
    output cwec_pkg::queue_head_t head,
    input  logic                  pop
);

    cwec_pkg::cmd_t q_mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    cwec_pkg::cmd_t new_cmd;
    logic           push;
    logic           outside;

    // A query of a cell beyond the rows and columns in use is a wall without looking it up.
    always_comb
    begin
        outside = ({1'b0, in_data.row} >= grid.rows) || ({1'b0, in_data.col} >= grid.cols);
        new_cmd.row     = in_data.row;
        new_cmd.col     = in_data.col;
        new_cmd.is_wall = in_data.is_wall;
        if (in_data.op == cwec_pkg::OP_LOAD)
        begin
            new_cmd.kind = cwec_pkg::CMD_LOAD;
        end
        else if (outside)
        begin
            new_cmd.kind = cwec_pkg::CMD_WALL;
        end
        else
        begin
            new_cmd.kind = cwec_pkg::CMD_QUERY;
        end
    end

    assign in_ready   = (count_reg != 2'd2) && !hold;
    assign push       = in_valid && in_ready;
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (pop && head.valid);
        count_next  = count_reg + 2'(push) - 2'(pop && head.valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> hw/rtl/cwec_back.sv
// Back end: executes loads and queries, walks regions, fills and sweeps the answer cache.
// Depends on cwec_pkg and cwec_ram.
module cwec_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cwec_pkg::grid_t       grid,
    input  logic                  clear_req,
    input  cwec_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  sweeping,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cwec_pkg::out_item_t   out_data
);

    cwec_pkg::back_state_t          state_reg, state_next;
    logic [cwec_pkg::EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [cwec_pkg::CELL_W-1:0]    sweep_idx_reg, sweep_idx_next;
    logic [cwec_pkg::CELL_W-1:0]    start_cell_reg, start_cell_next;
    logic [cwec_pkg::CELL_W-1:0]    cur_cell_reg, cur_cell_next;
    logic [cwec_pkg::CELL_W-1:0]    nb_cell_reg, nb_cell_next;
    logic [1:0]                     dir_reg, dir_next;
    logic [cwec_pkg::SLOT_W-1:0]    head_reg, head_next;
    logic [cwec_pkg::SLOT_W-1:0]    tail_reg, tail_next;
    logic [cwec_pkg::CNT_W-1:0]     acc_reg, acc_next;
    logic                           out_valid_reg, out_valid_next;
    cwec_pkg::out_item_t            out_data_reg, out_data_next;

    logic                           wall_we, wall_wdata, wall_rdata;
    logic [cwec_pkg::CELL_W-1:0]    wall_waddr, wall_raddr;
    logic                           ans_we;
    logic [cwec_pkg::CELL_W-1:0]    ans_waddr, ans_raddr;
    logic [cwec_pkg::ANS_W-1:0]     ans_wdata, ans_rdata;
    logic                           stk_we;
    logic [cwec_pkg::CELL_W-1:0]    stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    logic                           load_clear;
    logic                           nb_wall;
    logic [cwec_pkg::CELL_W-1:0]    nb_cell;
    logic [cwec_pkg::ROW_W-1:0]     cur_row;
    logic [cwec_pkg::COL_W-1:0]     cur_col;
    logic [cwec_pkg::CNT_W-1:0]     acc_inc;
    logic                           ans_hit;

    cwec_ram #(.WIDTH(1), .DEPTH(cwec_pkg::CELL_COUNT)) u_wall_ram (
        .clk   (clk),
        .we    (wall_we),
        .waddr (wall_waddr),
        .wdata (wall_wdata),
        .raddr (wall_raddr),
        .rdata (wall_rdata)
    );

    // Each word holds an epoch tag and a count; the tag doubles as the visited mark.
    cwec_ram #(.WIDTH(cwec_pkg::ANS_W), .DEPTH(cwec_pkg::CELL_COUNT)) u_ans_ram (
        .clk   (clk),
        .we    (ans_we),
        .waddr (ans_waddr),
        .wdata (ans_wdata),
        .raddr (ans_raddr),
        .rdata (ans_rdata)
    );

    cwec_ram #(.WIDTH(cwec_pkg::CELL_W), .DEPTH(cwec_pkg::CELL_COUNT)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign sweeping  = (state_reg == cwec_pkg::ST_SWEEP);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign ans_hit   = (ans_rdata[cwec_pkg::ANS_W-1 -: cwec_pkg::EPOCH_W] == epoch_reg);
    assign acc_inc   = (acc_reg == cwec_pkg::COUNT_MAX) ? acc_reg : acc_reg + 1'b1;

    // Neighbor in the current direction, and whether it lies outside the grid in use.
    always_comb
    begin
        cur_row = cwec_pkg::row_of(cur_cell_reg);
        cur_col = cwec_pkg::col_of(cur_cell_reg);
        nb_wall = 1'b0;
        nb_cell = cur_cell_reg;
        case (dir_reg)
            cwec_pkg::DIR_UP:
            begin
                nb_wall = (cur_row == '0);
                nb_cell = cwec_pkg::cell_of(cur_row - 1'b1, cur_col);
            end
            cwec_pkg::DIR_DOWN:
            begin
                nb_wall = (({1'b0, cur_row} + 1'b1) >= grid.rows);
                nb_cell = cwec_pkg::cell_of(cur_row + 1'b1, cur_col);
            end
            cwec_pkg::DIR_LEFT:
            begin
                nb_wall = (cur_col == '0);
                nb_cell = cwec_pkg::cell_of(cur_row, cur_col - 1'b1);
            end
            cwec_pkg::DIR_RIGHT:
            begin
                nb_wall = (({1'b0, cur_col} + 1'b1) >= grid.cols);
                nb_cell = cwec_pkg::cell_of(cur_row, cur_col + 1'b1);
            end
            default:
            begin
                nb_wall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        epoch_next      = epoch_reg;
        sweep_idx_next  = sweep_idx_reg;
        start_cell_next = start_cell_reg;
        cur_cell_next   = cur_cell_reg;
        nb_cell_next    = nb_cell_reg;
        dir_next        = dir_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        pop             = 1'b0;
        load_clear      = 1'b0;
        wall_we         = 1'b0;
        wall_waddr      = cwec_pkg::cell_of(head.cmd.row, head.cmd.col);
        wall_wdata      = head.cmd.is_wall;
        wall_raddr      = cwec_pkg::cell_of(head.cmd.row, head.cmd.col);
        ans_we          = 1'b0;
        ans_waddr       = nb_cell_reg;
        ans_wdata       = {epoch_reg, {cwec_pkg::CNT_W{1'b0}}};
        ans_raddr       = cwec_pkg::cell_of(head.cmd.row, head.cmd.col);
        stk_we          = 1'b0;
        stk_waddr       = tail_reg[cwec_pkg::CELL_W-1:0];
        stk_wdata       = nb_cell_reg;
        stk_raddr       = head_reg[cwec_pkg::CELL_W-1:0];

        case (state_reg)
            cwec_pkg::ST_SWEEP:
            begin
                ans_we         = 1'b1;
                ans_waddr      = sweep_idx_reg;
                ans_wdata      = '0;
                sweep_idx_next = sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == cwec_pkg::CELL_W'(cwec_pkg::CELL_COUNT - 1))
                begin
                    epoch_next = cwec_pkg::EPOCH_FIRST;
                    state_next = cwec_pkg::ST_IDLE;
                end
            end
            cwec_pkg::ST_IDLE:
            begin
                if (head.valid && (!out_valid_reg || out_ready))
                begin
                    pop = 1'b1;
                    case (head.cmd.kind)
                        cwec_pkg::CMD_LOAD:
                        begin
                            wall_we    = (int'(head.cmd.row) < cwec_pkg::MAX_ROWS) &&
                                         (int'(head.cmd.col) < cwec_pkg::MAX_COLS);
                            load_clear = 1'b1;
                        end
                        cwec_pkg::CMD_WALL:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{edge_count: '0, on_wall: 1'b1};
                        end
                        cwec_pkg::CMD_QUERY:
                        begin
                            start_cell_next = cwec_pkg::cell_of(head.cmd.row, head.cmd.col);
                            state_next      = cwec_pkg::ST_Q_CHECK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cwec_pkg::ST_Q_CHECK:
            begin
                if (wall_rdata)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{edge_count: '0, on_wall: 1'b1};
                    state_next     = cwec_pkg::ST_IDLE;
                end
                else if (ans_hit)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{edge_count: ans_rdata[cwec_pkg::CNT_W-1:0],
                                       on_wall: 1'b0};
                    state_next     = cwec_pkg::ST_IDLE;
                end
                else
                begin
                    ans_we     = 1'b1;
                    ans_waddr  = start_cell_reg;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = start_cell_reg;
                    head_next  = '0;
                    tail_next  = cwec_pkg::SLOT_W'(1);
                    acc_next   = '0;
                    state_next = cwec_pkg::ST_POP_RD;
                end
            end
            cwec_pkg::ST_POP_RD:
            begin
                if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    state_next = cwec_pkg::ST_FILL_RD;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = cwec_pkg::ST_POP_WAIT;
                end
            end
            cwec_pkg::ST_POP_WAIT:
            begin
                cur_cell_next = stk_rdata;
                dir_next      = cwec_pkg::DIR_UP;
                state_next    = cwec_pkg::ST_NB_RD;
            end
            cwec_pkg::ST_NB_RD:
            begin
                if (nb_wall)
                begin
                    acc_next   = acc_inc;
                    dir_next   = dir_reg + 1'b1;
                    state_next = (dir_reg == cwec_pkg::DIR_RIGHT) ? cwec_pkg::ST_POP_RD
                                                                  : cwec_pkg::ST_NB_RD;
                end
                else
                begin
                    wall_raddr   = nb_cell;
                    ans_raddr    = nb_cell;
                    nb_cell_next = nb_cell;
                    state_next   = cwec_pkg::ST_NB_EV;
                end
            end
            cwec_pkg::ST_NB_EV:
            begin
                if (wall_rdata)
                begin
                    acc_next = acc_inc;
                end
                else if (!ans_hit && (tail_reg < cwec_pkg::SLOT_W'(cwec_pkg::CELL_COUNT)))
                begin
                    ans_we    = 1'b1;
                    stk_we    = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                dir_next   = dir_reg + 1'b1;
                state_next = (dir_reg == cwec_pkg::DIR_RIGHT) ? cwec_pkg::ST_POP_RD
                                                              : cwec_pkg::ST_NB_RD;
            end
            cwec_pkg::ST_FILL_RD:
            begin
                if (head_reg == tail_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{edge_count: acc_reg, on_wall: 1'b0};
                    state_next     = cwec_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = cwec_pkg::ST_FILL_WR;
                end
            end
            cwec_pkg::ST_FILL_WR:
            begin
                ans_we     = 1'b1;
                ans_waddr  = stk_rdata;
                ans_wdata  = {epoch_reg, acc_reg};
                head_next  = head_reg + 1'b1;
                state_next = cwec_pkg::ST_FILL_RD;
            end
            default:
            begin
                state_next = cwec_pkg::ST_IDLE;
            end
        endcase

        // Clearing all marks moves to a fresh epoch; when the tags run out,
        // the answer RAM is swept back to the never-valid tag.
        if ((state_reg != cwec_pkg::ST_SWEEP) && (clear_req || load_clear))
        begin
            if (epoch_reg == cwec_pkg::EPOCH_MAX)
            begin
                sweep_idx_next = '0;
                state_next     = cwec_pkg::ST_SWEEP;
            end
            else
            begin
                epoch_next = epoch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cwec_pkg::ST_SWEEP;
            epoch_reg     <= cwec_pkg::EPOCH_FIRST;
            sweep_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            sweep_idx_reg <= sweep_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_cell_reg <= start_cell_next;
        cur_cell_reg   <= cur_cell_next;
        nb_cell_reg    <= nb_cell_next;
        dir_reg        <= dir_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        acc_reg        <= acc_next;
        out_data_reg   <= out_data_next;
    end

endmodule

>>> hw/rtl/component_wall_edge_counter.sv
// Steps: a load retires once it leaves the queue; a query outside the grid in use is
// answered straight from the queue, one on a wall or a cached region after a read of the
// wall and answer RAMs; an uncached query walks a region of N cells (per cell: a stack
// read and up to 4 neighbor reads), then stores its answer for every cell of the region.
// Throughput: one item in the back end at a time, set by the neighbor walk loop.
// Reset: a clearing pass over all 4096 words of the answer RAM holds in_ready low; the
// same pass recurs after every 255 clears, when the epoch tags wrap.
//
// Top level of the component wall edge counter. Depends on cwec_pkg, cwec_front,
// cwec_back (which holds the RAMs).
module component_wall_edge_counter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cwec_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cwec_pkg::out_item_t                   out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cwec_pkg::IDX_W-1:0]            cfg_index,
    input  logic [cwec_pkg::CFG_W-1:0]            cfg_data
);

    // The grid size registers. A write to either one also throws away every
    // visited mark and cached answer, which the back end does by moving to a
    // new epoch. Writes to unknown indexes are dropped without a clear.
    // Values above the grid size act as the full size, so they are stored
    // already limited to it.
    cwec_pkg::grid_t       grid_reg, grid_next;
    logic                  cfg_clear;
    logic                  hold;
    logic                  pop;
    cwec_pkg::queue_head_t head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        grid_next = grid_reg;
        cfg_clear = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                cwec_pkg::REG_GRID_ROWS:
                begin
                    grid_next.rows = (cfg_data > cwec_pkg::CFG_W'(cwec_pkg::MAX_ROWS)) ?
                                     cwec_pkg::CFG_W'(cwec_pkg::MAX_ROWS) : cfg_data;
                    cfg_clear      = 1'b1;
                end
                cwec_pkg::REG_GRID_COLS:
                begin
                    grid_next.cols = (cfg_data > cwec_pkg::CFG_W'(cwec_pkg::MAX_COLS)) ?
                                     cwec_pkg::CFG_W'(cwec_pkg::MAX_COLS) : cfg_data;
                    cfg_clear      = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= '{rows: cwec_pkg::CFG_W'(cwec_pkg::MAX_ROWS),
                          cols: cwec_pkg::CFG_W'(cwec_pkg::MAX_COLS)};
        end
        else
        begin
            grid_reg <= grid_next;
        end
    end

    // The front end takes transactions into a two-entry command queue and
    // marks queries outside the grid in use as wall hits up front.
    cwec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .grid     (grid_reg),
        .hold     (hold),
        .head     (head),
        .pop      (pop)
    );

    // The back end owns the wall map, the tagged answer cache and the work
    // stack, runs the region walk and drives the output register.
    cwec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid      (grid_reg),
        .clear_req (cfg_clear),
        .head      (head),
        .pop       (pop),
        .sweeping  (hold),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/cwec_checker.sv
// Port-level checker for the component wall edge counter, bound to the top level.
// Depends on cwec_pkg.
module cwec_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input cwec_pkg::in_item_t         in_data,
    input logic                       out_valid,
    input logic                       out_ready,
    input cwec_pkg::out_item_t        out_data,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [cwec_pkg::IDX_W-1:0] cfg_index,
    input logic [cwec_pkg::CFG_W-1:0] cfg_data
);

    // A result that waits keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A wall hit carries a zero count.
    a_wall_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.on_wall |-> out_data.edge_count == '0)
        else $error("wall result with nonzero count");

    // Any open region is bounded by at least four wall edges.
    a_min_perimeter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.on_wall |-> out_data.edge_count >= cwec_pkg::CNT_W'(4))
        else $error("open region with fewer than four edges");

    // The clearing pass after reset keeps the input closed.
    a_reset_closed: assert property (@(posedge clk)
        !rst_n |=> !in_ready)
        else $error("input open right after reset");

endmodule

bind component_wall_edge_counter cwec_checker u_cwec_checker (.*);
